// ===== rtl/rid_pkg.sv =====
// shared types and codes for the reversible indexed deque
// used by rid_front, rid_back and the top level; depends on nothing
`timescale 1ns / 1ps

package rid_pkg;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_LEFT  = 3'd0,
    MODE_PUSH_RIGHT = 3'd1,
    MODE_POP_LEFT   = 3'd2,
    MODE_POP_RIGHT  = 3'd3,
    MODE_GET        = 3'd4,
    MODE_SET        = 3'd5,
    MODE_REVERSE    = 3'd6,
    MODE_QUERY      = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_GET,
    OP_SET,
    OP_REV,
    OP_QUERY
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // one decoded operation as it sits in the command queue
  typedef struct packed {
    op_e              op;
    logic             left;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/rid_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rid_front.sv =====
// command front end: takes operations, decodes them and queues them
// uses rid_pkg for the mode codes and the queue entry type
`timescale 1ns / 1ps

module rid_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rid_pkg::MODE_W-1:0]    mode_i,
  input  logic [rid_pkg::IDX_W-1:0]     index_i,
  input  logic [rid_pkg::VAL_W-1:0]     value_i,
  output logic                          busy_o,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output rid_pkg::entry_t               q_entry_o
);

  localparam int unsigned QDEPTH = 2;

  rid_pkg::entry_t mem_q [QDEPTH];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      fill_q, fill_d;
  rid_pkg::entry_t dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.index = index_i;
    dec.value = value_i;
    dec.left  = 1'b0;
    dec.op    = rid_pkg::OP_QUERY;
    case (rid_pkg::mode_e'(mode_i))
      rid_pkg::MODE_PUSH_LEFT: begin
        dec.op   = rid_pkg::OP_PUSH;
        dec.left = 1'b1;
      end
      rid_pkg::MODE_PUSH_RIGHT: dec.op = rid_pkg::OP_PUSH;
      rid_pkg::MODE_POP_LEFT: begin
        dec.op   = rid_pkg::OP_POP;
        dec.left = 1'b1;
      end
      rid_pkg::MODE_POP_RIGHT: dec.op = rid_pkg::OP_POP;
      rid_pkg::MODE_GET:       dec.op = rid_pkg::OP_GET;
      rid_pkg::MODE_SET:       dec.op = rid_pkg::OP_SET;
      rid_pkg::MODE_REVERSE:   dec.op = rid_pkg::OP_REV;
      default:                 dec.op = rid_pkg::OP_QUERY;
    endcase
  end

  assign busy_o    = (fill_q == 2'(QDEPTH));
  assign push      = start_i && !busy_o;
  assign q_valid_o = (fill_q != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'(QDEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("command queue overflow");

  property p_fill_tracks;
    @(posedge clk_i) disable iff (!rst_ni)
      (push && !pop) |=> (fill_q == $past(fill_q) + 2'd1);
  endproperty
  a_fill_tracks: assert property (p_fill_tracks) else $error("queue fill lost a transfer");

endmodule

// ===== rtl/rid_back.sv =====
// execution back end: ring pointers, count, reverse flag, element ram and result
// uses rid_pkg for codes and the queue entry type, instantiates rid_ram
`timescale 1ns / 1ps

module rid_back #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  rid_pkg::entry_t                   q_entry_i,
  output logic                              done_o,
  output logic [rid_pkg::VAL_W-1:0]         read_value_o,
  output logic [rid_pkg::STAT_W-1:0]        status_o,
  output logic [$clog2(CAPACITY+1)-1:0]     count_o,
  output logic                              is_empty_o,
  output logic [rid_pkg::VAL_W-1:0]         left_value_o,
  output logic [rid_pkg::VAL_W-1:0]         right_value_o,
  output logic                              is_reversed_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > rid_pkg::IDX_W) ? CNT_W : rid_pkg::IDX_W;
  localparam logic [AW:0]      CAP_S = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_L,
    S_RD_R,
    S_FIN
  } state_e;

  state_e                 state_q;
  rid_pkg::entry_t        ent_q;
  logic [AW-1:0]          first_q, first_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   rev_q, rev_d;
  rid_pkg::status_e       status_q, status_d;
  logic                   get_q, get_d;
  logic [DATA_WIDTH-1:0]  rd_q, lv_q;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [DATA_WIDTH-1:0]  wdata, rdata;
  logic [DATA_WIDTH-1:0]  val;
  logic                   in_range;
  logic                   phys_front;
  logic [CNT_W-1:0]       idx_c, phys_idx, last_pos, pos_l, pos_r;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] first, logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, first} + {1'b0, pos};
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[AW-1:0];
  endfunction

  rid_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign val        = DATA_WIDTH'(ent_q.value);
  assign in_range   = CMP_W'(ent_q.index) < CMP_W'(count_q);
  assign idx_c      = CNT_W'(ent_q.index);
  assign phys_idx   = rev_q ? (count_q - CNT_W'(1) - idx_c) : idx_c;
  // left request hits the physical front unless reversed
  assign phys_front = ent_q.left ^ rev_q;
  // end positions after the operation, held in range when empty
  assign last_pos   = (count_q == '0) ? '0 : count_q - CNT_W'(1);
  assign pos_l      = rev_q ? last_pos : '0;
  assign pos_r      = rev_q ? '0 : last_pos;

  always_comb begin
    first_d  = first_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = rid_pkg::STAT_OK;
    get_d    = 1'b0;
    we       = 1'b0;
    waddr    = slot_of(first_q, AW'(phys_idx));
    wdata    = val;
    raddr    = slot_of(first_q, AW'(phys_idx));
    case (state_q)
      S_EXEC: begin
        case (ent_q.op)
          rid_pkg::OP_PUSH: begin
            if (count_q == CAP_C) begin
              status_d = rid_pkg::STAT_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (phys_front) begin
                first_d = (first_q == '0) ? LAST_SLOT : first_q - AW'(1);
                waddr   = first_d;
              end else begin
                waddr = slot_of(first_q, AW'(count_q));
              end
            end
          end
          rid_pkg::OP_POP: begin
            if (count_q == '0) begin
              status_d = rid_pkg::STAT_POP_EMPTY;
            end else begin
              count_d = count_q - CNT_W'(1);
              if (phys_front) begin
                first_d = (first_q == LAST_SLOT) ? '0 : first_q + AW'(1);
              end
            end
          end
          rid_pkg::OP_GET: begin
            if (in_range) begin
              get_d = 1'b1;
            end else begin
              status_d = rid_pkg::STAT_RANGE;
            end
          end
          rid_pkg::OP_SET: begin
            if (in_range) begin
              we = 1'b1;
            end else begin
              status_d = rid_pkg::STAT_RANGE;
            end
          end
          rid_pkg::OP_REV: rev_d = ~rev_q;
          default: ;
        endcase
      end
      S_RD_L: raddr = slot_of(first_q, AW'(pos_l));
      S_RD_R: raddr = slot_of(first_q, AW'(pos_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ent_q         <= '0;
      first_q       <= '0;
      count_q       <= '0;
      rev_q         <= 1'b0;
      status_q      <= rid_pkg::STAT_OK;
      get_q         <= 1'b0;
      rd_q          <= '0;
      lv_q          <= '0;
      done_o        <= 1'b0;
      read_value_o  <= '0;
      status_o      <= '0;
      count_o       <= '0;
      is_empty_o    <= 1'b1;
      left_value_o  <= '0;
      right_value_o <= '0;
      is_reversed_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            ent_q   <= q_entry_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          first_q  <= first_d;
          count_q  <= count_d;
          rev_q    <= rev_d;
          status_q <= status_d;
          get_q    <= get_d;
          state_q  <= S_RD_L;
        end
        S_RD_L: begin
          // data of the get read issued during exec
          rd_q    <= get_q ? rdata : '0;
          state_q <= S_RD_R;
        end
        S_RD_R: begin
          lv_q    <= rdata;
          state_q <= S_FIN;
        end
        S_FIN: begin
          done_o        <= 1'b1;
          read_value_o  <= rid_pkg::VAL_W'(rd_q);
          status_o      <= status_q;
          count_o       <= count_q;
          is_empty_o    <= (count_q == '0);
          left_value_o  <= (count_q == '0) ? '0 : rid_pkg::VAL_W'(lv_q);
          right_value_o <= (count_q == '0) ? '0 : rid_pkg::VAL_W'(rdata);
          is_reversed_o <= rev_q;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_C;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count above capacity");

  property p_first_bound;
    @(posedge clk_i) disable iff (!rst_ni) first_q <= LAST_SLOT;
  endproperty
  a_first_bound: assert property (p_first_bound) else $error("first slot out of ring");

  property p_done_after_fin;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(state_q == S_FIN);
  endproperty
  a_done_after_fin: assert property (p_done_after_fin) else $error("stray result strobe");

  property p_push_counts;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_EXEC && ent_q.op == rid_pkg::OP_PUSH && count_q != CAP_C)
        |=> (count_q == $past(count_q) + CNT_W'(1));
  endproperty
  a_push_counts: assert property (p_push_counts) else $error("push did not grow count");

endmodule

// ===== rtl/reversible_indexed_deque.sv =====
// top level of the reversible indexed deque
// depends on rid_pkg, rid_front, rid_back and rid_ram
`timescale 1ns / 1ps

// Double-ended queue with indexed get/set and an O(1) reverse. An operation is
// taken on a clock edge with start_i high and busy_o low; a two-entry command
// queue in front lets up to two operations wait while one executes. Each
// operation yields exactly one result, shown for one cycle with done_o high;
// the result cannot be held off, so capture it when done_o is seen. The back
// end runs each operation through dequeue, execute with the get read, left end
// read, right end read and result, an order set by the single read port of the
// element ram, and takes no new operation until the last result is out. busy_o
// rises only while the command queue is full. The element ram needs no
// clearing after reset.
module reversible_indexed_deque #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rid_pkg::MODE_W-1:0]     mode_i,
  input  logic [rid_pkg::IDX_W-1:0]      index_i,
  input  logic [rid_pkg::VAL_W-1:0]      value_i,
  output logic                           done_o,
  output logic [rid_pkg::VAL_W-1:0]      read_value_o,
  output logic [rid_pkg::STAT_W-1:0]     status_o,
  output logic [$clog2(CAPACITY+1)-1:0]  count_o,
  output logic                           is_empty_o,
  output logic [rid_pkg::VAL_W-1:0]      left_value_o,
  output logic [rid_pkg::VAL_W-1:0]      right_value_o,
  output logic                           is_reversed_o
);

  logic            q_valid;
  logic            q_pop;
  rid_pkg::entry_t q_entry;

  rid_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .mode_i    (mode_i),
    .index_i   (index_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_entry_o (q_entry)
  );

  rid_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_entry_i     (q_entry),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .left_value_o  (left_value_o),
    .right_value_o (right_value_o),
    .is_reversed_o (is_reversed_o)
  );

endmodule

// ===== tb/reversible_indexed_deque_tb.sv =====
// self-checking testbench for reversible_indexed_deque: an in-bench predictor
// tracks ring store, count and reversal flag; results are checked in order
// depends on rid_pkg and the reversible_indexed_deque rtl
`timescale 1ns / 1ps

module reversible_indexed_deque_tb;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef struct {
    logic [rid_pkg::VAL_W-1:0] read_value;
    rid_pkg::status_e          status;
    logic [CNT_W-1:0]          count;
    logic                      is_empty;
    logic [rid_pkg::VAL_W-1:0] left_value;
    logic [rid_pkg::VAL_W-1:0] right_value;
    logic                      is_reversed;
  } deque_view_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [rid_pkg::MODE_W-1:0]   mode_i;
  logic [rid_pkg::IDX_W-1:0]    index_i;
  logic [rid_pkg::VAL_W-1:0]    value_i;
  logic                         done_o;
  logic [rid_pkg::VAL_W-1:0]    read_value_o;
  logic [rid_pkg::STAT_W-1:0]   status_o;
  logic [CNT_W-1:0]             count_o;
  logic                         is_empty_o;
  logic [rid_pkg::VAL_W-1:0]    left_value_o;
  logic [rid_pkg::VAL_W-1:0]    right_value_o;
  logic                         is_reversed_o;

  // predicted deque contents
  logic [rid_pkg::VAL_W-1:0] slot_mem [DEPTH];
  logic [SLOT_W-1:0]         head_slot;
  logic [CNT_W-1:0]          occupancy;
  logic                      flipped;

  deque_view_t pending_views[$];
  int          mismatches;
  bit          idle_en;
  int          quiet_run;

  reversible_indexed_deque #(
    .CAPACITY  (DEPTH),
    .DATA_WIDTH(rid_pkg::VAL_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .left_value_o (left_value_o),
    .right_value_o(right_value_o),
    .is_reversed_o(is_reversed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // logical index to ring slot, mirrored when reversed
  function automatic logic [SLOT_W-1:0] slot_of_index(logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] pos;
    pos = flipped ? occupancy - CNT_W'(1) - idx : idx;
    return head_slot + pos[SLOT_W-1:0];
  endfunction

  function automatic deque_view_t deque_apply(rid_pkg::mode_e m,
                                              logic [rid_pkg::IDX_W-1:0] idx,
                                              logic [rid_pkg::VAL_W-1:0] val);
    deque_view_t v;
    logic        at_front;
    v.read_value = '0;
    v.status     = rid_pkg::STAT_OK;
    case (m)
      rid_pkg::MODE_PUSH_LEFT, rid_pkg::MODE_PUSH_RIGHT: begin
        at_front = (m == rid_pkg::MODE_PUSH_LEFT) != flipped;
        if (occupancy == CNT_W'(DEPTH)) begin
          v.status = rid_pkg::STAT_FULL;
        end else begin
          if (at_front) begin
            head_slot = head_slot - SLOT_W'(1);
            slot_mem[head_slot] = val;
          end else begin
            slot_mem[head_slot + occupancy[SLOT_W-1:0]] = val;
          end
          occupancy = occupancy + CNT_W'(1);
        end
      end
      rid_pkg::MODE_POP_LEFT, rid_pkg::MODE_POP_RIGHT: begin
        at_front = (m == rid_pkg::MODE_POP_LEFT) != flipped;
        if (occupancy == '0) begin
          v.status = rid_pkg::STAT_POP_EMPTY;
        end else begin
          if (at_front) head_slot = head_slot + SLOT_W'(1);
          occupancy = occupancy - CNT_W'(1);
        end
      end
      rid_pkg::MODE_GET: begin
        if (idx < rid_pkg::IDX_W'(occupancy))
          v.read_value = slot_mem[slot_of_index(idx[CNT_W-1:0])];
        else v.status = rid_pkg::STAT_RANGE;
      end
      rid_pkg::MODE_SET: begin
        if (idx < rid_pkg::IDX_W'(occupancy)) slot_mem[slot_of_index(idx[CNT_W-1:0])] = val;
        else v.status = rid_pkg::STAT_RANGE;
      end
      rid_pkg::MODE_REVERSE: flipped = !flipped;
      default: ;
    endcase
    v.count       = occupancy;
    v.is_empty    = (occupancy == '0);
    v.left_value  = (occupancy == '0) ? '0 : slot_mem[slot_of_index('0)];
    v.right_value = (occupancy == '0) ? '0 : slot_mem[slot_of_index(occupancy - CNT_W'(1))];
    v.is_reversed = flipped;
    return v;
  endfunction

  // one transfer; start_i stays high when the next item follows without a gap
  task automatic send_op(rid_pkg::mode_e m, logic [rid_pkg::IDX_W-1:0] idx,
                         logic [rid_pkg::VAL_W-1:0] val);
    if (idle_en) begin
      if (quiet_run > 0) begin
        quiet_run--;
      end else if ($urandom_range(0, 9) == 0) begin
        quiet_run = $urandom_range(10, 40);
      end else if ($urandom_range(0, 3) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    mode_i  <= m;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (busy_o);
    pending_views.push_back(deque_apply(m, idx, val));
  endtask

  function automatic logic [rid_pkg::IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && occupancy != '0)
      return rid_pkg::IDX_W'($urandom_range(0, occupancy - CNT_W'(1)));
    else if (r < 8) return rid_pkg::IDX_W'(occupancy);
    else return rid_pkg::IDX_W'($urandom_range(0, 65535));
  endfunction

  // push and pop weights in percent, the rest spread over get, set, reverse, query and a random mode
  task automatic send_random(int push_pct, int pop_pct);
    int             r;
    rid_pkg::mode_e m;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      m = $urandom_range(0, 1) ? rid_pkg::MODE_PUSH_LEFT : rid_pkg::MODE_PUSH_RIGHT;
    else if (r < push_pct + pop_pct)
      m = $urandom_range(0, 1) ? rid_pkg::MODE_POP_LEFT : rid_pkg::MODE_POP_RIGHT;
    else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = rid_pkg::MODE_GET;
        4, 5, 6:    m = rid_pkg::MODE_SET;
        7:          m = rid_pkg::MODE_REVERSE;
        8:          m = rid_pkg::MODE_QUERY;
        default:    m = rid_pkg::mode_e'($urandom_range(0, 7));
      endcase
    end
    send_op(m, pick_index(), $urandom());
  endtask

  task automatic compare_field(string field, logic [rid_pkg::VAL_W-1:0] want,
                               logic [rid_pkg::VAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  task automatic check_result();
    deque_view_t want;
    if (pending_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result strobe with no transfer outstanding");
    end else begin
      want = pending_views.pop_front();
      compare_field("read_value", want.read_value, read_value_o);
      compare_field("status", rid_pkg::VAL_W'(want.status), rid_pkg::VAL_W'(status_o));
      compare_field("count", rid_pkg::VAL_W'(want.count), rid_pkg::VAL_W'(count_o));
      compare_field("is_empty", rid_pkg::VAL_W'(want.is_empty), rid_pkg::VAL_W'(is_empty_o));
      compare_field("left_value", want.left_value, left_value_o);
      compare_field("right_value", want.right_value, right_value_o);
      compare_field("is_reversed", rid_pkg::VAL_W'(want.is_reversed),
                    rid_pkg::VAL_W'(is_reversed_o));
    end
  endtask

  // sample mid-cycle, away from the edge where the sender works
  always @(negedge clk_i) begin
    if (rst_ni && done_o) check_result();
  end

  task automatic test_directed();
    send_op(rid_pkg::MODE_QUERY, '0, '0);
    send_op(rid_pkg::MODE_GET, '0, '0);
    send_op(rid_pkg::MODE_SET, '0, 32'hdead_beef);
    send_op(rid_pkg::MODE_POP_LEFT, '0, '0);
    send_op(rid_pkg::MODE_POP_RIGHT, '0, '0);
    send_op(rid_pkg::MODE_REVERSE, '0, '0);
    send_op(rid_pkg::MODE_PUSH_LEFT, '0, 32'hffff_ffff);
    send_op(rid_pkg::MODE_REVERSE, '0, '0);
    send_op(rid_pkg::MODE_PUSH_RIGHT, 16'hffff, 32'h0000_0000);
    send_op(rid_pkg::MODE_PUSH_LEFT, '0, 32'ha5a5_a5a5);
    send_op(rid_pkg::MODE_GET, 16'd0, '0);
    send_op(rid_pkg::MODE_GET, 16'd2, '0);
    send_op(rid_pkg::MODE_GET, 16'd3, '0);
    send_op(rid_pkg::MODE_GET, 16'hffff, '0);
    send_op(rid_pkg::MODE_SET, 16'd1, 32'h1234_5678);
    send_op(rid_pkg::MODE_SET, 16'hffff, 32'h5a5a_5a5a);
    send_op(rid_pkg::MODE_REVERSE, '0, '0);
    send_op(rid_pkg::MODE_GET, 16'd0, '0);
    send_op(rid_pkg::MODE_GET, 16'd1, '0);
    send_op(rid_pkg::MODE_PUSH_LEFT, '0, 32'h8000_0001);
    send_op(rid_pkg::MODE_PUSH_RIGHT, '0, 32'h7fff_fffe);
    send_op(rid_pkg::MODE_POP_LEFT, '0, '0);
    send_op(rid_pkg::MODE_POP_RIGHT, '0, '0);
    send_op(rid_pkg::MODE_QUERY, 16'h8000, 32'hffff_ffff);
  endtask

  task automatic test_random_mix();
    repeat (400) send_random(35, 25);
  endtask

  // grows the deque from both ends across the ring wrap, then drains to empty
  task automatic test_fill_and_drain();
    repeat (120) send_random(75, 10);
    send_op(rid_pkg::MODE_PUSH_LEFT, '0, $urandom());
    send_op(rid_pkg::MODE_PUSH_RIGHT, '0, $urandom());
    send_op(rid_pkg::MODE_GET, rid_pkg::IDX_W'(occupancy - CNT_W'(1)), '0);
    send_op(rid_pkg::MODE_GET, rid_pkg::IDX_W'(occupancy), '0);
    send_op(rid_pkg::MODE_SET, rid_pkg::IDX_W'(occupancy - CNT_W'(1)), $urandom());
    send_op(rid_pkg::MODE_SET, rid_pkg::IDX_W'(occupancy), $urandom());
    send_op(rid_pkg::MODE_REVERSE, '0, '0);
    send_op(rid_pkg::MODE_PUSH_LEFT, '0, $urandom());
    send_op(rid_pkg::MODE_PUSH_RIGHT, '0, $urandom());
    send_op(rid_pkg::MODE_GET, '0, '0);
    send_op(rid_pkg::MODE_QUERY, '0, '0);
    while (occupancy != '0) send_random(10, 75);
    send_op(rid_pkg::MODE_POP_LEFT, '0, '0);
    send_op(rid_pkg::MODE_POP_RIGHT, '0, '0);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (150) send_random(40, 25);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
    head_slot  = '0;
    occupancy  = '0;
    flipped    = 1'b0;
    mismatches = 0;
    idle_en    = 1'b1;
    quiet_run  = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    mode_i     = rid_pkg::MODE_QUERY;
    index_i    = '0;
    value_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_fill_and_drain();
    test_back_to_back();

    start_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
